[rtl/tac_pkg.sv]
// shared types and constants of the tag allowlist controller
package tac_pkg;

  localparam int UID_BYTES = 7;
  localparam int TAG_SLOTS = 16;
  localparam int UID_W     = 56;
  localparam int KEY_BITS  = (UID_BYTES * 8 < UID_W) ? UID_BYTES * 8 : UID_W;
  localparam int SLOT_W    = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

  localparam logic [UID_W-1:0] UID_MASK = UID_W'((64'(1) << KEY_BITS) - 64'(1));

  typedef enum logic [2:0] {
    OC_DENIED  = 3'd0,
    OC_TOGGLED = 3'd1,
    OC_ADDED   = 3'd2,
    OC_REMOVED = 3'd3,
    OC_FULL    = 3'd4,
    OC_GRANTED = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_SCAN,
    CT_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_READ,
    SC_DRAIN,
    SC_DECIDE
  } scan_state_t;

  typedef struct packed {
    logic             start;
    logic             admin;
    logic [UID_W-1:0] uid;
  } scan_req_t;

  typedef struct packed {
    logic     done;
    outcome_t outcome;
  } scan_rsp_t;

endpackage

[rtl/tac_ram.sv]
// generic single-port-write ram with registered read
module tac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/tac_scanner.sv]
// table scan sequencer: one slot compare per cycle, then add, remove or look-up decision
module tac_scanner
  import tac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_req_t req,
  output scan_rsp_t rsp
);

  scan_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] addr_r, addr_nxt;
  logic [SLOT_W-1:0] rd_idx_r;
  logic              rd_pend_r, rd_pend_nxt;
  logic [UID_W-1:0]  uid_r;
  logic              admin_r;
  logic              hit_found_r, empty_found_r;
  logic [SLOT_W-1:0] hit_idx_r, empty_idx_r;
  logic [TAG_SLOTS-1:0] vld_r;

  logic [UID_W-1:0]  rd_data;
  logic [UID_W-1:0]  entry;
  logic              match, empty;
  logic              wr_en;
  logic              clr_en;
  outcome_t          outcome;

  tac_ram #(
    .WIDTH (UID_W),
    .DEPTH (TAG_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (empty_idx_r),
    .wr_data (uid_r),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // shared compare unit: slot value against the key and against zero
  assign entry = vld_r[rd_idx_r] ? rd_data : '0;
  assign match = (entry == uid_r);
  assign empty = (entry == '0);

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    rd_pend_nxt = 1'b0;
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    outcome     = OC_DENIED;
    rsp.done    = 1'b0;
    case (state_r)
      SC_IDLE: begin
        addr_nxt = '0;
        if (req.start) begin
          state_nxt = SC_READ;
        end
      end
      SC_READ: begin
        rd_pend_nxt = 1'b1;
        if (addr_r == SLOT_W'(TAG_SLOTS - 1)) begin
          state_nxt = SC_DRAIN;
        end else begin
          addr_nxt = addr_r + SLOT_W'(1);
        end
      end
      SC_DRAIN: begin
        state_nxt = SC_DECIDE;
      end
      SC_DECIDE: begin
        rsp.done  = 1'b1;
        state_nxt = SC_IDLE;
        if (admin_r) begin
          if (hit_found_r) begin
            clr_en  = 1'b1;
            outcome = OC_REMOVED;
          end else if (empty_found_r) begin
            wr_en   = 1'b1;
            outcome = OC_ADDED;
          end else begin
            outcome = OC_FULL;
          end
        end else if (hit_found_r && (uid_r != '0)) begin
          outcome = OC_GRANTED;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
    rsp.outcome = outcome;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SC_IDLE;
      rd_pend_r     <= 1'b0;
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      vld_r         <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (state_r == SC_IDLE && req.start) begin
        hit_found_r   <= 1'b0;
        empty_found_r <= 1'b0;
      end else if (rd_pend_r) begin
        if (match && !hit_found_r) begin
          hit_found_r <= 1'b1;
        end
        if (empty && !empty_found_r) begin
          empty_found_r <= 1'b1;
        end
      end
      // a cleared slot reads as zero through its valid bit
      if (clr_en) begin
        vld_r[hit_idx_r] <= 1'b0;
      end
      if (wr_en) begin
        vld_r[empty_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    rd_idx_r <= addr_r;
    if (state_r == SC_IDLE && req.start) begin
      uid_r   <= req.uid;
      admin_r <= req.admin;
    end
    if (rd_pend_r && match && !hit_found_r) begin
      hit_idx_r <= rd_idx_r;
    end
    if (rd_pend_r && empty && !empty_found_r) begin
      empty_idx_r <= rd_idx_r;
    end
  end

endmodule

[rtl/tag_allowlist_controller.sv]
// top level of the tag allowlist controller: handshakes, master check, admin mode
//
//   port group   direction  transfer rule
//   in_*         in         in_valid high and in_stall low at a rising edge
//   out_*        out        out_valid high and out_stall low at a rising edge
//   cfg_*        in         cfg_wr_en high at a rising edge writes master uid
//
// a master card skips the table scan and its result goes from the result
// register to the output register; any other card waits for the table scan
// that reads one slot a cycle through the single read port of the tag ram
// reset (rst_n low at a clock edge) empties the table, enters normal mode and
// clears master uid; no clearing pass, valid bits empty the table at once
// a stalled result sits in the output register while the next card transfers
module tag_allowlist_controller
  import tac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [UID_W-1:0]  in_card_uid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_outcome,
  output logic              out_access_granted,
  output logic              out_admin_active,
  input  logic              cfg_wr_en,
  input  logic [UID_W-1:0]  cfg_wr_data
);

  ctl_state_t       state_r, state_nxt;
  logic [UID_W-1:0] master_r;
  logic             admin_r, admin_nxt;
  outcome_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  outcome_t         out_outcome_r;
  logic             out_admin_r;

  logic             in_xfer;
  logic [UID_W-1:0] key;
  logic             is_master;
  logic             load_out;
  scan_req_t        scan_req;
  scan_rsp_t        scan_rsp;

  // only the low key bits of a uid take part in any compare
  assign key       = in_card_uid & UID_MASK;
  assign is_master = (key == (master_r & UID_MASK));
  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != CT_IDLE);

  // the scan is skipped for the master card in both modes
  assign scan_req.start = in_xfer && !is_master;
  assign scan_req.admin = admin_r;
  assign scan_req.uid   = key;

  tac_scanner u_scanner (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scan_req),
    .rsp   (scan_rsp)
  );

  // output register frees up when empty or when its transfer happens now
  assign load_out = (state_r == CT_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    admin_nxt     = admin_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      CT_IDLE: begin
        if (in_xfer) begin
          if (is_master) begin
            res_nxt   = OC_TOGGLED;
            state_nxt = CT_DONE;
          end else begin
            state_nxt = CT_SCAN;
          end
        end
      end
      CT_SCAN: begin
        if (scan_rsp.done) begin
          res_nxt   = scan_rsp.outcome;
          state_nxt = CT_DONE;
        end
      end
      CT_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = CT_IDLE;
          if (res_r == OC_TOGGLED) begin
            admin_nxt = !admin_r;
          end
        end
      end
      default: begin
        state_nxt = CT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CT_IDLE;
      admin_r     <= 1'b0;
      out_valid_r <= 1'b0;
      master_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      admin_r     <= admin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        master_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (load_out) begin
      out_outcome_r <= res_r;
      out_admin_r   <= admin_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_access_granted = (out_outcome_r == OC_GRANTED);
  assign out_admin_active   = out_admin_r;

  // scanner answers only while the controller waits for it
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_rsp.done |-> (state_r == CT_SCAN))
    else $error("scan finished outside of scan wait");

  // a master card result flips admin mode
  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_r == OC_TOGGLED) |=> (admin_r != $past(admin_r)))
    else $error("admin mode not toggled by master card");

  // table edits and full reports only come out of admin mode
  a_admin_outcomes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == OC_ADDED || out_outcome == OC_REMOVED ||
                   out_outcome == OC_FULL)) |-> out_admin_active)
    else $error("table edit reported outside admin mode");

  // no grant while in admin mode
  a_no_grant_admin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_granted) |-> !out_admin_active)
    else $error("access granted in admin mode");

endmodule
